// ===== rtl/mcgo_pkg.sv =====
// shared types, constants and glyph font for the marker circle glyph overlay
package mcgo_pkg;

   localparam int COORD_W = 10;
   localparam int COLOR_W = 8;
   localparam int RADIUS_W = 6;
   localparam int SELECT_W = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 10;

   // glyph geometry: 5x7 dots, top-left corner at (cx-5, cy-6)
   localparam int GLYPH_W = 5;
   localparam int GLYPH_H = 7;
   localparam int GLYPH_ORG_X = 5;
   localparam int GLYPH_ORG_Y = 6;
   localparam int GLYPH_SCALE_DEFAULT = 2;

   // signed offset from the centre, one bit wider than a coordinate
   localparam int DELTA_W = COORD_W + 1;
   // glyph-relative offset, room for the origin shift
   localparam int OFFS_W = COORD_W + 2;
   localparam int SQUARE_W = 2 * COORD_W;
   localparam int DIST_W = SQUARE_W + 1;
   localparam int THRESH_W = 2 * (RADIUS_W + 1) - 1;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = 8'd255;
   localparam logic [COLOR_W-1:0] COLOR_BLACK = 8'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X     = 2'd0,
      CSR_CENTER_Y     = 2'd1,
      CSR_RADIUS       = 2'd2,
      CSR_GLYPH_SELECT = 2'd3
   } csr_index_type;

   typedef enum logic [SELECT_W-1:0] {
      GLYPH_OFF = 3'd0,
      GLYPH_R   = 3'd1,
      GLYPH_G   = 3'd2,
      GLYPH_B   = 3'd3,
      GLYPH_Y   = 3'd4
   } glyph_select_type;

   typedef struct packed {
      logic [COORD_W-1:0]  center_x;
      logic [COORD_W-1:0]  center_y;
      logic [RADIUS_W-1:0] radius;
      logic [SELECT_W-1:0] glyph_select;
   } cfg_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   typedef logic [GLYPH_W-1:0] glyph_row_type;
   typedef glyph_row_type glyph_font_type [0:3][0:7];

   // eighth row is blank so a three-bit row index stays in bounds
   localparam glyph_font_type GLYPH_FONT = '{
      '{5'h1E, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h00},
      '{5'h0E, 5'h11, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0E, 5'h00},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h00},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00}
   };

   function automatic logic marker_enabled(input logic [SELECT_W-1:0] sel);
      marker_enabled = (sel == GLYPH_R) || (sel == GLYPH_G) ||
                       (sel == GLYPH_B) || (sel == GLYPH_Y);
   endfunction

   function automatic logic glyph_dot(input logic [1:0] font,
                                      input logic [2:0] row,
                                      input logic [2:0] col);
      glyph_row_type bits;
      logic [2:0]    bit_idx;
      bits = GLYPH_FONT[font][row];
      bit_idx = 3'(GLYPH_W - 1) - col;
      glyph_dot = bits[bit_idx];
   endfunction

endpackage

// ===== rtl/mcgo_ifs.sv =====
// pixel channel interfaces for the overlay, request and response sides
interface mcgo_req_if;
   import mcgo_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic [COLOR_W-1:0] red_in;
   logic [COLOR_W-1:0] green_in;
   logic [COLOR_W-1:0] blue_in;

   modport source (output valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                 output ready);
endinterface

interface mcgo_rsp_if;
   import mcgo_pkg::*;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red_out;
   logic [COLOR_W-1:0] green_out;
   logic [COLOR_W-1:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== rtl/mcgo_csr.sv =====
// marker configuration registers with their write decode
module mcgo_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [mcgo_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mcgo_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output mcgo_pkg::cfg_type                cfg
);
   import mcgo_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X:     cfg_in.center_x = csr_wdata[COORD_W-1:0];
            CSR_CENTER_Y:     cfg_in.center_y = csr_wdata[COORD_W-1:0];
            CSR_RADIUS:       cfg_in.radius = csr_wdata[RADIUS_W-1:0];
            CSR_GLYPH_SELECT: cfg_in.glyph_select = csr_wdata[SELECT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x <= '0;
         cfg_ff.center_y <= '0;
         cfg_ff.radius <= RADIUS_W'(14);
         cfg_ff.glyph_select <= GLYPH_OFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/mcgo_pipe.sv =====
// three-stage overlay pipeline: offsets, squares and glyph dot, ring compare
module mcgo_pipe #(
   parameter int GLYPH_SCALE = mcgo_pkg::GLYPH_SCALE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  mcgo_pkg::cfg_type cfg,
   mcgo_req_if.sink          req_chan,
   mcgo_rsp_if.source        rsp_chan
);
   import mcgo_pkg::*;

   localparam int GlyphWidthPx = GLYPH_W * GLYPH_SCALE;
   localparam int GlyphHeightPx = GLYPH_H * GLYPH_SCALE;
   localparam int CellW = $clog2(GlyphHeightPx);

   // stage enables, each stage moves when it is empty or the next one moves
   logic en1, en2, en3;

   // stage 1: centre distances and glyph-relative offsets
   logic                       v1_ff;
   logic [COORD_W-1:0]         adx1_ff, adx1_in;
   logic [COORD_W-1:0]         ady1_ff, ady1_in;
   logic signed [OFFS_W-1:0]   u1_ff, u1_in;
   logic signed [OFFS_W-1:0]   v1off_ff, v1off_in;
   rgb_type                    rgb1_ff;
   logic signed [DELTA_W-1:0]  dx, dy;

   // stage 2: squares, thresholds and glyph dot
   logic                       v2_ff;
   logic [SQUARE_W-1:0]        sqx2_ff, sqx2_in;
   logic [SQUARE_W-1:0]        sqy2_ff, sqy2_in;
   logic [THRESH_W-1:0]        outer2_ff, outer2_in;
   logic [THRESH_W-1:0]        inner2_ff, inner2_in;
   logic                       rzero2_ff;
   logic                       hit2_ff, hit2_in;
   rgb_type                    rgb2_ff;
   logic [RADIUS_W:0]          rp1, rm1;
   logic [CellW-1:0]           u_cell, v_cell;
   logic [2:0]                 g_col, g_row;
   logic                       in_box;

   // stage 3: ring and fill decision, output register
   logic                       v3_ff;
   rgb_type                    rgb3_ff, rgb3_in;
   logic [DIST_W-1:0]          d2;
   logic                       ring, fill;

   // glyph dot index from a pixel offset, compares against multiples of the scale
   function automatic logic [2:0] cell_index(input logic [CellW-1:0] offs);
      logic [2:0] idx;
      idx = '0;
      for (int k = 1; k < 8; k++) begin
         if (int'(offs) >= k * GLYPH_SCALE) begin
            idx = 3'(k);
         end
      end
      return idx;
   endfunction

   assign en3 = !v3_ff || rsp_chan.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   always_comb begin
      dx = $signed({1'b0, req_chan.pixel_x}) - $signed({1'b0, cfg.center_x});
      dy = $signed({1'b0, req_chan.pixel_y}) - $signed({1'b0, cfg.center_y});
      adx1_in = dx[DELTA_W-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ady1_in = dy[DELTA_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      u1_in = $signed({2'b00, req_chan.pixel_x}) - $signed({2'b00, cfg.center_x})
              + OFFS_W'(GLYPH_ORG_X);
      v1off_in = $signed({2'b00, req_chan.pixel_y}) - $signed({2'b00, cfg.center_y})
                 + OFFS_W'(GLYPH_ORG_Y);
   end

   always_comb begin
      sqx2_in = adx1_ff * adx1_ff;
      sqy2_in = ady1_ff * ady1_ff;
      rp1 = {1'b0, cfg.radius} + 1'b1;
      // radius zero gives an inner bound of one, as (0-1)^2
      rm1 = (cfg.radius == '0) ? (RADIUS_W+1)'(1) : ({1'b0, cfg.radius} - 1'b1);
      outer2_in = THRESH_W'(rp1) * THRESH_W'(rp1);
      inner2_in = THRESH_W'(rm1) * THRESH_W'(rm1);
      in_box = !u1_ff[OFFS_W-1] && !v1off_ff[OFFS_W-1] &&
               (u1_ff < OFFS_W'(GlyphWidthPx)) && (v1off_ff < OFFS_W'(GlyphHeightPx));
      u_cell = u1_ff[CellW-1:0];
      v_cell = v1off_ff[CellW-1:0];
      g_col = cell_index(u_cell);
      g_row = cell_index(v_cell);
      hit2_in = in_box && glyph_dot(2'(cfg.glyph_select - 1'b1), g_row, g_col);
   end

   always_comb begin
      d2 = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
      ring = (d2 < DIST_W'(outer2_ff)) && (rzero2_ff || d2 >= DIST_W'(inner2_ff));
      fill = !rzero2_ff && (d2 < DIST_W'(inner2_ff));
      rgb3_in = rgb2_ff;
      if (marker_enabled(cfg.glyph_select)) begin
         if (ring || hit2_ff) begin
            rgb3_in = '{COLOR_BLACK, COLOR_BLACK, COLOR_BLACK};
         end else if (fill) begin
            rgb3_in = '{COLOR_WHITE, COLOR_WHITE, COLOR_WHITE};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         adx1_ff <= adx1_in;
         ady1_ff <= ady1_in;
         u1_ff <= u1_in;
         v1off_ff <= v1off_in;
         rgb1_ff <= '{req_chan.red_in, req_chan.green_in, req_chan.blue_in};
      end
      if (en2) begin
         sqx2_ff <= sqx2_in;
         sqy2_ff <= sqy2_in;
         outer2_ff <= outer2_in;
         inner2_ff <= inner2_in;
         rzero2_ff <= (cfg.radius == '0);
         hit2_ff <= hit2_in;
         rgb2_ff <= rgb1_ff;
      end
      if (en3) begin
         rgb3_ff <= rgb3_in;
      end
   end

   assign rsp_chan.valid = v3_ff;
   assign rsp_chan.red_out = rgb3_ff.red;
   assign rsp_chan.green_out = rgb3_ff.green;
   assign rsp_chan.blue_out = rgb3_ff.blue;

   a_reset_empties: assert property (@(posedge clock) reset |=> !v3_ff)
      else $error("output stage valid after reset");

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !en2 |=> v1_ff && $stable(rgb1_ff))
      else $error("stalled stage one lost its item");

   a_marker_off_passes: assert property (@(posedge clock) disable iff (reset)
      en3 && v2_ff && !marker_enabled(cfg.glyph_select) |=> rgb3_ff == $past(rgb2_ff))
      else $error("pixel altered with marker off");

   a_glyph_black: assert property (@(posedge clock) disable iff (reset)
      en3 && v2_ff && hit2_ff && marker_enabled(cfg.glyph_select)
      |=> rgb3_ff == rgb_type'{COLOR_BLACK, COLOR_BLACK, COLOR_BLACK})
      else $error("glyph dot not drawn black");

endmodule

// ===== rtl/marker_circle_glyph_overlay_top.sv =====
// Marker overlay top level. Pixels stream in with their column and row and come out in the
// same order, either unchanged or painted with one marker: a black ring two pixels thick at
// the configured radius, a white disc inside it, and a black 5x7 letter (R, G, B or Y)
// scaled by GLYPH_SCALE with its corner at (center_x-5, center_y-6). Glyph select 0 (or any
// code above 4) turns the marker off. Throughput is one pixel per cycle while the response
// side is ready; the three register stages are offsets, squares with glyph lookup and
// distance compare. Write the registers only while no pixel is in flight.
module marker_circle_glyph_overlay_top #(
   parameter int GLYPH_SCALE = mcgo_pkg::GLYPH_SCALE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [mcgo_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mcgo_pkg::CSR_DATA_W-1:0]  csr_wdata,
   mcgo_req_if.sink                         req_chan,
   mcgo_rsp_if.source                       rsp_chan
);
   import mcgo_pkg::*;

   cfg_type cfg;

   mcgo_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   mcgo_pipe #(
      .GLYPH_SCALE (GLYPH_SCALE)
   ) u_pipe (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the marker circle glyph overlay: directed table, then random phases
`timescale 1ns / 1ps

module testbench;
   import mcgo_pkg::*;

   localparam int DOT_SCALE = GLYPH_SCALE_DEFAULT;
   localparam int COORD_MAX = (1 << COORD_W) - 1;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_ITEMS = 125;
   localparam int FLOOD_PHASE = 3;
   localparam int LONG_HOLD = 120;
   localparam int TAIL_CYCLES = 12;

   // select codes above the last letter, marker stays off
   localparam logic [SELECT_W-1:0] SEL_UNUSED_LO = 3'd5;
   localparam logic [SELECT_W-1:0] SEL_UNUSED_HI = 3'd7;

   // 5x7 letters R, G, B, Y, msb is the leftmost dot
   localparam logic [4:0] LETTER_DOTS [4][7] = '{
      '{5'h1E, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11},
      '{5'h0E, 5'h11, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04}
   };

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      rgb_type            color;
   } pixel_type;

   typedef struct {
      cfg_type   marker;
      pixel_type pix;
      bit        typed;
      rgb_type   result;
   } directed_row_type;

   typedef enum int {
      DRAIN_FREELY,
      DRAIN_MOSTLY,
      DRAIN_PATTERN,
      DRAIN_SPARSE
   } drain_style_type;

   localparam rgb_type BLACK_RGB = '{8'd0, 8'd0, 8'd0};
   localparam rgb_type WHITE_RGB = '{8'd255, 8'd255, 8'd255};

   localparam cfg_type MARKER_AT_RESET = '{10'd0, 10'd0, 6'd14, GLYPH_OFF};
   localparam cfg_type RING_R14 = '{10'd100, 10'd100, 6'd14, GLYPH_R};
   localparam cfg_type DOT_R0 = '{10'd100, 10'd100, 6'd0, GLYPH_G};
   localparam cfg_type CORNER_R1 = '{10'd0, 10'd0, 6'd1, GLYPH_B};
   localparam cfg_type FAR_R63 = '{10'd1023, 10'd1023, 6'd63, GLYPH_Y};
   localparam cfg_type OFF_LO = '{10'd500, 10'd500, 6'd20, SEL_UNUSED_LO};
   localparam cfg_type OFF_HI = '{10'd500, 10'd500, 6'd20, SEL_UNUSED_HI};

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mcgo_req_if req_chan();
   mcgo_rsp_if rsp_chan();

   cfg_type marker = MARKER_AT_RESET;
   rgb_type expected_colors [$];
   int mismatches = 0;
   bit hold_request = 1'b0;

   directed_row_type directed_rows [22] = '{
      '{MARKER_AT_RESET, '{10'd0, 10'd0, '{8'd12, 8'd34, 8'd56}}, 1'b1,
        '{8'd12, 8'd34, 8'd56}},
      '{MARKER_AT_RESET, '{10'd1023, 10'd1023, WHITE_RGB}, 1'b1, WHITE_RGB},
      '{MARKER_AT_RESET, '{10'd512, 10'd511, BLACK_RGB}, 1'b1, BLACK_RGB},
      '{RING_R14, '{10'd100, 10'd100, '{8'd1, 8'd2, 8'd3}}, 1'b0, BLACK_RGB},
      '{RING_R14, '{10'd114, 10'd100, '{8'd1, 8'd2, 8'd3}}, 1'b1, BLACK_RGB},
      '{RING_R14, '{10'd115, 10'd100, '{8'd10, 8'd20, 8'd30}}, 1'b1,
        '{8'd10, 8'd20, 8'd30}},
      '{RING_R14, '{10'd113, 10'd100, '{8'd200, 8'd100, 8'd50}}, 1'b1, BLACK_RGB},
      '{RING_R14, '{10'd112, 10'd100, BLACK_RGB}, 1'b1, WHITE_RGB},
      // glyph corner dot sits inside the white disc
      '{RING_R14, '{10'd95, 10'd94, '{8'd77, 8'd88, 8'd99}}, 1'b1, BLACK_RGB},
      '{RING_R14, '{10'd1023, 10'd0, '{8'd5, 8'd6, 8'd7}}, 1'b1,
        '{8'd5, 8'd6, 8'd7}},
      '{DOT_R0, '{10'd100, 10'd100, '{8'd9, 8'd9, 8'd9}}, 1'b1, BLACK_RGB},
      '{DOT_R0, '{10'd101, 10'd100, '{8'd9, 8'd9, 8'd9}}, 1'b0, BLACK_RGB},
      '{DOT_R0, '{10'd100, 10'd115, '{8'd40, 8'd50, 8'd60}}, 1'b1,
        '{8'd40, 8'd50, 8'd60}},
      '{CORNER_R1, '{10'd0, 10'd0, '{8'd255, 8'd0, 8'd255}}, 1'b1, BLACK_RGB},
      '{CORNER_R1, '{10'd1, 10'd1, '{8'd1, 8'd1, 8'd1}}, 1'b0, BLACK_RGB},
      '{CORNER_R1, '{10'd2, 10'd2, '{8'd3, 8'd3, 8'd3}}, 1'b0, BLACK_RGB},
      '{FAR_R63, '{10'd1023, 10'd1023, '{8'd8, 8'd8, 8'd8}}, 1'b0, BLACK_RGB},
      '{FAR_R63, '{10'd960, 10'd1023, WHITE_RGB}, 1'b1, BLACK_RGB},
      '{FAR_R63, '{10'd1000, 10'd1000, '{8'd0, 8'd128, 8'd0}}, 1'b1, WHITE_RGB},
      '{FAR_R63, '{10'd0, 10'd0, '{8'd17, 8'd18, 8'd19}}, 1'b1,
        '{8'd17, 8'd18, 8'd19}},
      '{OFF_LO, '{10'd500, 10'd500, '{8'd31, 8'd32, 8'd33}}, 1'b1,
        '{8'd31, 8'd32, 8'd33}},
      '{OFF_HI, '{10'd510, 10'd500, '{8'd64, 8'd65, 8'd66}}, 1'b1,
        '{8'd64, 8'd65, 8'd66}}
   };

   marker_circle_glyph_overlay_top #(.GLYPH_SCALE(DOT_SCALE)) DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   // colour of one pixel after the ring, the disc and the letter are laid over it
   function automatic rgb_type paint_pixel(input cfg_type m, input pixel_type p);
      int dx, dy, d2, rad, ring_out, ring_in, u, v;
      logic [4:0] dots;
      rgb_type c;
      c = p.color;
      if (m.glyph_select >= GLYPH_R && m.glyph_select <= GLYPH_Y) begin
         dx = int'(p.col) - int'(m.center_x);
         dy = int'(p.row) - int'(m.center_y);
         d2 = dx * dx + dy * dy;
         rad = int'(m.radius);
         ring_out = (rad + 1) * (rad + 1);
         ring_in = (rad - 1) * (rad - 1);
         if (d2 < ring_out && (rad == 0 || d2 >= ring_in)) begin
            c = BLACK_RGB;
         end else if (rad >= 1 && d2 < ring_in) begin
            c = WHITE_RGB;
         end
         u = int'(p.col) - (int'(m.center_x) - 5);
         v = int'(p.row) - (int'(m.center_y) - 6);
         if (u >= 0 && v >= 0 && u < 5 * DOT_SCALE && v < 7 * DOT_SCALE) begin
            dots = LETTER_DOTS[int'(m.glyph_select) - 1][v / DOT_SCALE];
            if (dots[4 - u / DOT_SCALE]) begin
               c = BLACK_RGB;
            end
         end
      end
      return c;
   endfunction

   function automatic logic [COORD_W-1:0] near_coord(input int base, input int lo,
                                                     input int hi);
      int v;
      v = base + lo + int'($urandom_range(0, hi - lo));
      if (v < 0) begin
         v = 0;
      end
      if (v > COORD_MAX) begin
         v = COORD_MAX;
      end
      return COORD_W'(v);
   endfunction

   // most pixels land around the ring or on the letter, the rest anywhere
   function automatic pixel_type random_pixel();
      pixel_type p;
      int pick, span;
      pick = $urandom_range(0, 9);
      span = int'(marker.radius) + 3;
      if (pick < 6) begin
         p.col = near_coord(int'(marker.center_x), -span, span);
         p.row = near_coord(int'(marker.center_y), -span, span);
      end else if (pick < 8) begin
         p.col = near_coord(int'(marker.center_x) - 5, -2, 5 * DOT_SCALE + 1);
         p.row = near_coord(int'(marker.center_y) - 6, -2, 7 * DOT_SCALE + 1);
      end else begin
         p.col = COORD_W'($urandom);
         p.row = COORD_W'($urandom);
      end
      p.color = {8'($urandom), 8'($urandom), 8'($urandom)};
      return p;
   endfunction

   function automatic cfg_type random_marker(input int phase);
      cfg_type m;
      m.center_x = COORD_W'($urandom);
      m.center_y = COORD_W'($urandom);
      m.radius = RADIUS_W'($urandom);
      if ($urandom_range(0, 9) < 8) begin
         m.glyph_select = SELECT_W'($urandom_range(GLYPH_R, GLYPH_Y));
      end else begin
         m.glyph_select = SELECT_W'($urandom);
      end
      case (phase)
         0: begin
            m.center_x = '0;
            m.center_y = '0;
            m.radius = '1;
         end
         1: begin
            m.center_x = '1;
            m.center_y = '1;
            m.radius = '0;
         end
         2: begin
            m.center_x = '1;
            m.center_y = '0;
            m.radius = RADIUS_W'(1);
         end
         PHASE_COUNT - 1: m.glyph_select = GLYPH_OFF;
         default: ;
      endcase
      return m;
   endfunction

   task automatic log_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch: %s", what);
      end
   endtask

   // unused upper bits of the write data carry junk, the registers must ignore it
   task automatic program_marker(input cfg_type m);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      csr_write_en <= 1'b1;
      csr_index <= CSR_CENTER_X;
      csr_wdata <= m.center_x;
      @(posedge clock);
      csr_index <= CSR_CENTER_Y;
      csr_wdata <= m.center_y;
      @(posedge clock);
      csr_index <= CSR_RADIUS;
      csr_wdata <= {junk[CSR_DATA_W-1:RADIUS_W], m.radius};
      @(posedge clock);
      csr_index <= CSR_GLYPH_SELECT;
      csr_wdata <= {junk[CSR_DATA_W-1:SELECT_W], m.glyph_select};
      @(posedge clock);
      csr_write_en <= 1'b0;
      marker = m;
   endtask

   task automatic offer_pixel(input pixel_type p, input bit typed, input rgb_type typed_result);
      req_chan.valid <= 1'b1;
      req_chan.pixel_x <= p.col;
      req_chan.pixel_y <= p.row;
      req_chan.red_in <= p.color.red;
      req_chan.green_in <= p.color.green;
      req_chan.blue_in <= p.color.blue;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      expected_colors.push_back(typed ? typed_result : paint_pixel(marker, p));
   endtask

   task automatic rest(input int cycles);
      if (cycles > 0) begin
         req_chan.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      while (expected_colors.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : check_result
      rgb_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_colors.size() == 0) begin
            log_mismatch($sformatf("unexpected item %02x %02x %02x", rsp_chan.red_out,
                                   rsp_chan.green_out, rsp_chan.blue_out));
         end else begin
            want = expected_colors.pop_front();
            if (rsp_chan.red_out !== want.red || rsp_chan.green_out !== want.green ||
                rsp_chan.blue_out !== want.blue) begin
               log_mismatch($sformatf("expected %02x %02x %02x got %02x %02x %02x",
                                      want.red, want.green, want.blue, rsp_chan.red_out,
                                      rsp_chan.green_out, rsp_chan.blue_out));
            end
         end
      end
   end

   initial begin : receiver
      drain_style_type style;
      int style_left, hold_left, tick;
      logic [15:0] pattern;
      style = DRAIN_FREELY;
      style_left = 0;
      hold_left = 0;
      tick = 0;
      pattern = '1;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (style_left == 0) begin
            style = drain_style_type'($urandom_range(DRAIN_FREELY, DRAIN_SPARSE));
            style_left = $urandom_range(20, 200);
            pattern = 16'($urandom);
         end
         style_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (style)
               DRAIN_FREELY: rsp_chan.ready <= 1'b1;
               DRAIN_MOSTLY: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               DRAIN_PATTERN: rsp_chan.ready <= pattern[tick % 16];
               default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   initial begin : stimulus
      int phase, n, burst_left;
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= CSR_CENTER_X;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.pixel_x <= '0;
      req_chan.pixel_y <= '0;
      req_chan.red_in <= '0;
      req_chan.green_in <= '0;
      req_chan.blue_in <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].marker != marker) begin
            drain_pipeline();
            program_marker(directed_rows[i].marker);
         end
         offer_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].result);
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_pipeline();
         program_marker(random_marker(phase));
         // receiver holds off while the sender keeps pushing, so the pipe backs up
         if (phase == FLOOD_PHASE) begin
            hold_request = 1'b1;
         end
         burst_left = 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               if (phase != FLOOD_PHASE && phase % 4 != 1) begin
                  rest($urandom_range(0, 6));
               end
               burst_left = $urandom_range(1, 40);
            end
            offer_pixel(random_pixel(), 1'b0, BLACK_RGB);
            burst_left--;
         end
      end

      drain_pipeline();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
